FILE: src/pfct_pkg.sv
// Shared types, codes and constants of the potential field contour test core.
package pfct_pkg;

    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 28;
    localparam int EXP_INT_LIMIT = 24;
    localparam int SQRT_STEPS    = 17;
    localparam int NBR_COUNT     = 8;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [10:0] x_coord;
        logic [10:0] y_coord;
    } in_t;

    typedef struct packed {
        logic               is_contour;
        logic signed [27:0] penalty;
        logic [4:0]         stored_points;
        logic               dropped;
    } out_t;

    typedef struct packed {
        logic       capture;
        logic       add;
        logic       clear;
        logic       eval_start;
        logic       center;
        logic [2:0] nbr;
        logic       sq1;
        logic       sq2;
        logic       sqrt_step;
        logic       exp_mul;
        logic       rom_read;
        logic       w_mul;
        logic       a_mul;
        logic       acc_add;
        logic       sat;
        logic       keep_center;
        logic       set_contour;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic above;
        logic below;
        logic out_free;
    } status_t;

endpackage

FILE: src/pfct_ctrl.sv
// Sequencer of the potential field contour test core.
module pfct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_func,
    output logic             in_stall,
    input  pfct_pkg::status_t st,
    output pfct_pkg::cmd_t   cmd
);
    import pfct_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_ADD    = 16'h0002,
        S_CLEAR  = 16'h0004,
        S_FIN    = 16'h0008,
        S_EVAL   = 16'h0010,
        S_FETCH  = 16'h0020,
        S_SQ1    = 16'h0040,
        S_SQ2    = 16'h0080,
        S_SQRT   = 16'h0100,
        S_EXPM   = 16'h0200,
        S_ROMR   = 16'h0400,
        S_WMUL   = 16'h0800,
        S_AMUL   = 16'h1000,
        S_ACC    = 16'h2000,
        S_SAT    = 16'h4000,
        S_DECIDE = 16'h8000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] nbr_reg, nbr_next;
    logic       center_reg, center_next;
    logic [4:0] step_reg, step_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        nbr_next    = nbr_reg;
        center_next = center_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.center  = center_reg;
        cmd.nbr     = nbr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    center_next = 1'b1;
                    nbr_next    = '0;
                    case (in_func)
                        FUNC_ADD:   state_next = S_ADD;
                        FUNC_CLEAR: state_next = S_CLEAR;
                        FUNC_QUERY: state_next = S_EVAL;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_FIN;
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_FIN;
            end
            S_EVAL:
            begin
                cmd.eval_start = 1'b1;
                state_next     = st.empty ? S_SAT : S_FETCH;
            end
            S_FETCH: state_next = S_SQ1;
            S_SQ1:
            begin
                cmd.sq1    = 1'b1;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.sq2    = 1'b1;
                step_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 5'd1;
                if (step_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = S_EXPM;
                end
            end
            S_EXPM:
            begin
                cmd.exp_mul = 1'b1;
                state_next  = S_ROMR;
            end
            S_ROMR:
            begin
                cmd.rom_read = 1'b1;
                state_next   = S_WMUL;
            end
            S_WMUL:
            begin
                cmd.w_mul  = 1'b1;
                state_next = S_AMUL;
            end
            S_AMUL:
            begin
                cmd.a_mul  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = st.last ? S_SAT : S_FETCH;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (center_reg)
                begin
                    cmd.keep_center = 1'b1;
                    center_next     = 1'b0;
                    nbr_next        = '0;
                    state_next      = st.above ? S_EVAL : S_FIN;
                end
                else if (st.below)
                begin
                    cmd.set_contour = 1'b1;
                    state_next      = S_FIN;
                end
                else if (nbr_reg == 3'(NBR_COUNT - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    nbr_next   = nbr_reg + 3'd1;
                    state_next = S_EVAL;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nbr_reg    <= '0;
            center_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            nbr_reg    <= nbr_next;
            center_reg <= center_next;
            step_reg   <= step_next;
        end
    end

endmodule

FILE: src/pfct_dp.sv
// Datapath of the potential field contour test core: registers, point store, field unit.
module pfct_dp #(
    parameter int MAX_POINTS      = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pfct_pkg::in_t                      in_data,
    input  logic                               cfg_write,
    input  logic [pfct_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pfct_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  pfct_pkg::cmd_t                     cmd,
    output pfct_pkg::status_t                  st,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pfct_pkg::out_t                     out_data
);
    import pfct_pkg::*;

    localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = $clog2(EXP_TABLE_DEPTH);
    localparam int FPW = 17 + IW;
    localparam int AW  = $clog2(MAX_POINTS) + 28;
    localparam logic signed [AW-1:0] SAT_HI = AW'(134217727);
    localparam logic signed [AW-1:0] SAT_LO = -AW'(134217728);

    typedef logic [30:0] rom_t [EXP_TABLE_DEPTH];
    typedef logic [30:0] ptab_t [EXP_INT_LIMIT];

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] t;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
        begin
            t    = (64'(k) << 30) / EXP_TABLE_DEPTH;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int i = 1; i <= 20; i++)
            begin
                term = ((term * t) >> 30) / 64'(i);
                if ((i & 1) != 0)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            r[k] = 31'(sum);
        end
        return r;
    endfunction

    function automatic ptab_t build_ptab();
        ptab_t       p;
        logic [63:0] v;
        p[0] = 31'(64'd1 << 30);
        for (int k = 1; k < EXP_INT_LIMIT; k++)
        begin
            v    = (64'(p[k-1]) * 64'd395007542 + (64'd1 << 29)) >> 30;
            p[k] = 31'(v);
        end
        return p;
    endfunction

    localparam rom_t  EXP_ROM = build_rom();
    localparam ptab_t PTAB    = build_ptab();

    logic [1:0]         rot_reg;
    logic [10:0]        w_cfg_reg, h_cfg_reg;
    logic signed [23:0] amp_reg;
    logic [15:0]        decay_reg;
    logic signed [27:0] thr_reg;

    in_t                item_reg;
    logic signed [11:0] x_mem [MAX_POINTS];
    logic signed [11:0] y_mem [MAX_POINTS];
    logic signed [11:0] rd_x_reg, rd_y_reg;
    logic [CW-1:0]      total_reg;
    logic [PW-1:0]      pidx_reg;
    logic               dropped_reg;

    logic signed [12:0] px_reg, py_reg;
    logic signed [13:0] dx, dy;
    logic signed [27:0] dx_prod, dy_prod;
    logic [24:0]        dxsq_reg;
    logic [25:0]        d2;
    logic [33:0]        v_reg;
    logic [34:0]        res_reg;
    logic [33:0]        bit_reg;
    logic [34:0]        trial;
    logic [33:0]        e_reg;
    logic [FPW-1:0]     fprod;
    logic               skip_reg;
    logic [4:0]         n_reg;
    logic [30:0]        t_reg;
    logic [30:0]        p_val;
    logic [61:0]        wprod;
    logic [30:0]        w_reg;
    logic [23:0]        mag;
    logic [54:0]        aprod;
    logic [24:0]        tm_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [27:0] pen_reg;
    logic signed [27:0] center_pen_reg;
    logic               contour_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    logic [11:0]        add_x, add_y;
    logic signed [1:0]  off_x, off_y;
    logic signed [12:0] xs, ys, wlim, hlim;
    logic               in_border;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg   <= ROT_0;
            w_cfg_reg <= 11'd1024;
            h_cfg_reg <= 11'd1024;
            amp_reg   <= '0;
            decay_reg <= '0;
            thr_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROTATION:  rot_reg   <= cfg_data[1:0];
                CFG_WIDTH:     w_cfg_reg <= cfg_data[10:0];
                CFG_HEIGHT:    h_cfg_reg <= cfg_data[10:0];
                CFG_AMPLITUDE: amp_reg   <= cfg_data[23:0];
                CFG_DECAY:     decay_reg <= cfg_data[15:0];
                CFG_THRESHOLD: thr_reg   <= cfg_data[27:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (rot_reg)
            ROT_90:
            begin
                add_x = {1'b0, item_reg.y_coord};
                add_y = {1'b0, h_cfg_reg} - {1'b0, item_reg.x_coord};
            end
            ROT_180:
            begin
                add_x = {1'b0, w_cfg_reg} - {1'b0, item_reg.x_coord};
                add_y = {1'b0, h_cfg_reg} - {1'b0, item_reg.y_coord};
            end
            ROT_270:
            begin
                add_x = {1'b0, w_cfg_reg} - {1'b0, item_reg.y_coord};
                add_y = {1'b0, item_reg.x_coord};
            end
            default:
            begin
                add_x = {1'b0, item_reg.x_coord};
                add_y = {1'b0, item_reg.y_coord};
            end
        endcase
    end

    always_comb
    begin
        case (cmd.nbr)
            3'd0:    begin off_x = -2'sd1; off_y = -2'sd1; end
            3'd1:    begin off_x = -2'sd1; off_y =  2'sd0; end
            3'd2:    begin off_x = -2'sd1; off_y =  2'sd1; end
            3'd3:    begin off_x =  2'sd0; off_y = -2'sd1; end
            3'd4:    begin off_x =  2'sd0; off_y =  2'sd1; end
            3'd5:    begin off_x =  2'sd1; off_y = -2'sd1; end
            3'd6:    begin off_x =  2'sd1; off_y =  2'sd0; end
            default: begin off_x =  2'sd1; off_y =  2'sd1; end
        endcase
        if (cmd.center)
        begin
            off_x = 2'sd0;
            off_y = 2'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.add && (total_reg != CW'(MAX_POINTS)))
        begin
            x_mem[total_reg[PW-1:0]] <= add_x;
            y_mem[total_reg[PW-1:0]] <= add_y;
        end
        rd_x_reg <= x_mem[pidx_reg];
        rd_y_reg <= y_mem[pidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            dropped_reg <= 1'b0;
            pidx_reg    <= '0;
        end
        else
        begin
            if (cmd.capture)
                dropped_reg <= 1'b0;
            if (cmd.clear)
                total_reg <= '0;
            if (cmd.add)
            begin
                if (total_reg == CW'(MAX_POINTS))
                    dropped_reg <= 1'b1;
                else
                    total_reg <= total_reg + CW'(1);
            end
            if (cmd.eval_start)
                pidx_reg <= '0;
            else if (cmd.acc_add && !st.last)
                pidx_reg <= pidx_reg + PW'(1);
        end
    end

    assign dx      = 14'(px_reg) - 14'(rd_x_reg);
    assign dy      = 14'(py_reg) - 14'(rd_y_reg);
    assign dx_prod = dx * dx;
    assign dy_prod = dy * dy;
    assign d2      = 26'(dxsq_reg) + 26'(dy_prod[24:0]);
    assign trial   = res_reg + 35'(bit_reg);
    assign fprod   = FPW'(e_reg[15:0]) * FPW'(EXP_TABLE_DEPTH);
    assign p_val   = (n_reg < 5'(EXP_INT_LIMIT)) ? PTAB[n_reg] : '0;
    assign wprod   = 62'(t_reg) * 62'(p_val) + (62'd1 << 29);
    assign mag     = amp_reg[23] ? 24'(-amp_reg) : 24'(amp_reg);
    assign aprod   = 55'(mag) * 55'(w_reg) + (55'd1 << 29);

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            px_reg <= $signed({2'b00, item_reg.x_coord}) + 13'(off_x);
            py_reg <= $signed({2'b00, item_reg.y_coord}) + 13'(off_y);
        end
        if (cmd.sq1)
            dxsq_reg <= dx_prod[24:0];
        if (cmd.sq2)
        begin
            v_reg   <= {d2, 8'b0};
            res_reg <= '0;
            bit_reg <= 34'd1 << 32;
        end
        else if (cmd.sqrt_step)
        begin
            if (35'(v_reg) >= trial)
            begin
                v_reg   <= v_reg - trial[33:0];
                res_reg <= (res_reg >> 1) + 35'(bit_reg);
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.exp_mul)
            e_reg <= 34'(res_reg[17:0]) * 34'(decay_reg);
        if (cmd.rom_read)
        begin
            skip_reg <= (e_reg[33:16] >= 18'(EXP_INT_LIMIT));
            n_reg    <= e_reg[20:16];
            t_reg    <= EXP_ROM[fprod[16 +: IW]];
        end
        if (cmd.w_mul)
            w_reg <= skip_reg ? '0 : wprod[60:30];
        if (cmd.a_mul)
            tm_reg <= aprod[54:30];
        if (cmd.eval_start)
            acc_reg <= '0;
        else if (cmd.acc_add)
            acc_reg <= amp_reg[23] ? acc_reg - $signed(AW'(tm_reg))
                                   : acc_reg + $signed(AW'(tm_reg));
        if (cmd.sat)
        begin
            if (acc_reg > SAT_HI)
                pen_reg <= SAT_HI[27:0];
            else if (acc_reg < SAT_LO)
                pen_reg <= SAT_LO[27:0];
            else
                pen_reg <= acc_reg[27:0];
        end
        if (cmd.capture)
        begin
            center_pen_reg <= '0;
            contour_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.keep_center)
                center_pen_reg <= pen_reg;
            if (cmd.set_contour)
                contour_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_reg.is_contour    <= contour_reg;
            out_reg.penalty       <= center_pen_reg;
            out_reg.stored_points <= 5'(total_reg);
            out_reg.dropped       <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign xs        = $signed({2'b00, item_reg.x_coord});
    assign ys        = $signed({2'b00, item_reg.y_coord});
    assign wlim      = $signed({2'b00, w_cfg_reg}) - 13'sd2;
    assign hlim      = $signed({2'b00, h_cfg_reg}) - 13'sd2;
    assign in_border = (xs >= 13'sd1) && (xs <= wlim) && (ys >= 13'sd1) && (ys <= hlim);

    assign st.empty    = (total_reg == '0);
    assign st.last     = (CW'(pidx_reg) + CW'(1) == total_reg);
    assign st.above    = in_border && (pen_reg > thr_reg);
    assign st.below    = (pen_reg < thr_reg);
    assign st.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (total_reg == '0))
        else $error("clear left points in store");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.add && (total_reg != CW'(MAX_POINTS))) |=> (total_reg == $past(total_reg) + CW'(1)))
        else $error("add did not advance point count");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_step |-> $onehot0(bit_reg))
        else $error("sqrt bit register corrupt");
`endif

endmodule

FILE: src/potential_field_contour_test_core.sv
// Top level of the potential field contour test core.
// Holds up to MAX_POINTS repulsion points and answers one result per transfer in. A query
// runs one field pass for the pixel and, when the pixel is inside the border and above
// threshold, up to eight more for its neighbors, stopping at the first neighbor below
// threshold; each pass walks the N stored points through the bit-serial square root (17
// steps) and the exp multiplies on the one shared field unit. A new transfer is taken once
// the previous item has placed its result in the output register.
module potential_field_contour_test_core #(
    parameter int MAX_POINTS      = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  pfct_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output pfct_pkg::out_t                   out_data,
    input  logic                             cfg_write,
    input  logic [pfct_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pfct_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfct_pkg::*;

    cmd_t    cmd;
    status_t st;

    pfct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    pfct_dp #(
        .MAX_POINTS      (MAX_POINTS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the potential field contour test core: penalty field, store and contour flag.
`timescale 1ns / 100ps

module testbench;
    import pfct_pkg::*;

    localparam int MAX_PTS   = 16;
    localparam int EXP_DEPTH = 256;
    localparam int IDLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    potential_field_contour_test_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    longint unsigned frac_tab[EXP_DEPTH];
    longint unsigned int_tab[EXP_INT_LIMIT];
    logic signed [11:0] px_store[MAX_PTS];
    logic signed [11:0] py_store[MAX_PTS];
    int    pt_count;
    logic [1:0] rot;
    int    img_w, img_h;
    longint amp, thresh;
    longint unsigned decay;

    out_t  result_queue[$];
    int    mismatches = 0;
    bit    rx_hold = 1'b0;
    bit    quiet = 1'b0;
    int    idle_cycles = 0;

    function automatic void build_exp_tables();
        longint unsigned t, term;
        longint sum;
        for (int k = 0; k < EXP_DEPTH; k++)
        begin
            t = (longint'(k) << 30) / EXP_DEPTH;
            term = 64'd1 << 30;
            sum = longint'(term);
            for (int i = 1; i <= 20; i++)
            begin
                term = ((term * t) >> 30) / i;
                if (i & 1) sum -= longint'(term); else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            frac_tab[k] = sum;
        end
        int_tab[0] = 64'd1 << 30;
        for (int k = 1; k < EXP_INT_LIMIT; k++)
            int_tab[k] = (int_tab[k-1] * 64'd395007542 + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 40;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint penalty_at(int x, int y);
        longint acc, dx, dy;
        longint unsigned mag, d2, e, n, idx, w, t;
        acc = 0;
        mag = (amp < 0) ? -amp : amp;
        for (int i = 0; i < pt_count; i++)
        begin
            dx = x - px_store[i];
            dy = y - py_store[i];
            d2 = dx * dx + dy * dy;
            e = int_sqrt(d2 << 8) * decay;
            n = e >> 16;
            if (n >= EXP_INT_LIMIT) continue;
            idx = ((e & 64'hFFFF) * EXP_DEPTH) >> 16;
            if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
            w = (frac_tab[idx] * int_tab[n] + (64'd1 << 29)) >> 30;
            t = (mag * w + (64'd1 << 29)) >> 30;
            acc += (amp < 0) ? -longint'(t) : longint'(t);
        end
        if (acc > 134217727) acc = 134217727;
        if (acc < -134217728) acc = -134217728;
        return acc;
    endfunction

    function automatic out_t predict_item(in_t item);
        out_t r;
        int x, y, sx, sy;
        longint pen;
        r = '0;
        x = item.x_coord;
        y = item.y_coord;
        case (item.func)
            FUNC_ADD:
                if (pt_count >= MAX_PTS) r.dropped = 1'b1;
                else
                begin
                    case (rot)
                        ROT_90:  begin sx = y;         sy = img_h - x; end
                        ROT_180: begin sx = img_w - x; sy = img_h - y; end
                        ROT_270: begin sx = img_w - y; sy = x;         end
                        default: begin sx = x;         sy = y;         end
                    endcase
                    px_store[pt_count] = sx[11:0];
                    py_store[pt_count] = sy[11:0];
                    pt_count++;
                end
            FUNC_CLEAR: pt_count = 0;
            FUNC_QUERY:
            begin
                pen = penalty_at(x, y);
                r.penalty = pen[27:0];
                if (x >= 1 && x <= img_w - 2 && y >= 1 && y <= img_h - 2 && pen > thresh)
                    for (int ddx = -1; ddx <= 1; ddx++)
                        for (int ddy = -1; ddy <= 1; ddy++)
                            if ((ddx != 0 || ddy != 0) && !r.is_contour)
                                if (penalty_at(x + ddx, y + ddy) < thresh) r.is_contour = 1'b1;
            end
            default: ;
        endcase
        r.stored_points = pt_count[4:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_ROTATION:  rot = val[1:0];
            CFG_WIDTH:     img_w = val[10:0];
            CFG_HEIGHT:    img_h = val[10:0];
            CFG_AMPLITUDE: amp = longint'($signed(val[23:0]));
            CFG_DECAY:     decay = val[15:0];
            CFG_THRESHOLD: thresh = longint'($signed(val[27:0]));
            default: ;
        endcase
    endtask

    task automatic send_item(logic [1:0] f, int x, int y);
        in_t item;
        item.func = f;
        item.x_coord = x[10:0];
        item.y_coord = y[10:0];
        while (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
        result_queue.insert(result_queue.size(), predict_item(item));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (result_queue.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_field(logic [1:0] r, int w, int h, longint a, longint d, longint th);
        drain();
        write_reg(CFG_ROTATION, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_AMPLITUDE, a);
        write_reg(CFG_DECAY, d);
        write_reg(CFG_THRESHOLD, th);
    endtask

    task automatic test_directed();
        set_field(ROT_0, 64, 48, 25600, 4096, 6400);
        send_item(FUNC_QUERY, 10, 10);
        send_item(FUNC_ADD, 20, 20);
        send_item(FUNC_QUERY, 20, 20);
        send_item(FUNC_QUERY, 21, 20);
        send_item(FUNC_QUERY, 0, 20);
        send_item(FUNC_QUERY, 2047, 2047);
        send_item(FUNC_SPARE, 2047, 0);
        send_item(FUNC_CLEAR, 0, 0);
        for (int i = 0; i < 17; i++) send_item(FUNC_ADD, 2047 - i, i * 100);
        send_item(FUNC_QUERY, 0, 0);
        send_item(FUNC_CLEAR, 5, 5);
        set_field(ROT_90, 3, 1024, -8388608, 65535, -134217728);
        send_item(FUNC_ADD, 0, 2047);
        send_item(FUNC_QUERY, 1, 1);
        set_field(ROT_180, 1024, 3, 8388607, 0, 134217727);
        send_item(FUNC_ADD, 2047, 0);
        send_item(FUNC_QUERY, 1, 1);
        set_field(ROT_270, 1024, 1024, 8388607, 1, 0);
        send_item(FUNC_ADD, 1024, 2047);
        send_item(FUNC_QUERY, 500, 500);
        send_item(FUNC_CLEAR, 0, 0);
    endtask

    task automatic test_random(int count);
        int x, y, cx, cy, n;
        longint a;
        n = 0;
        while (n < count)
        begin
            a = $urandom_range(1, 30000);
            if ($urandom_range(3) == 0) a = -a;
            set_field(2'($urandom_range(3)), $urandom_range(16, 64), $urandom_range(16, 64),
                      a, $urandom_range(200, 3000), $urandom_range(0, 3) * (a / 4));
            send_item(FUNC_CLEAR, $urandom_range(2047), $urandom_range(2047));
            cx = $urandom_range(4, 40);
            cy = $urandom_range(4, 40);
            for (int i = 0; i < $urandom_range(1, 4); i++)
            begin
                send_item(FUNC_ADD, cx + $urandom_range(8), cy + $urandom_range(8));
                n++;
            end
            for (int i = 0; i < 30; i++)
            begin
                x = cx + $urandom_range(16) - 8;
                y = cy + $urandom_range(16) - 8;
                case ($urandom_range(19))
                    0: send_item(FUNC_ADD, $urandom_range(2047), $urandom_range(2047));
                    1: send_item(FUNC_SPARE, $urandom_range(2047), $urandom_range(2047));
                    2: send_item(FUNC_QUERY, $urandom_range(2047), $urandom_range(2047));
                    default: send_item(FUNC_QUERY, x, y);
                endcase
                n++;
            end
        end
    endtask

    task automatic test_backpressure();
        set_field(ROT_0, 32, 32, 2560, 2048, 256);
        fork
            begin
                rx_hold = 1'b1;
                repeat (1500) @(negedge clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_item(FUNC_ADD, i, i * 2);
        join
        drain();
        quiet = 1'b1;
        for (int i = 0; i < 40; i++) send_item(FUNC_QUERY, $urandom_range(31), $urandom_range(31));
        quiet = 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= rx_hold || (!quiet && $urandom_range(99) < 24);

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", out_data);
            end
            else
            begin
                if (out_data !== result_queue[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", result_queue[0], out_data);
                end
                void'(result_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** potential_field_contour_test_core: FAILED **");
            $finish;
        end

    initial
    begin
        build_exp_tables();
        pt_count = 0;
        rot = ROT_0;
        img_w = 1024;
        img_h = 1024;
        amp = 0;
        decay = 0;
        thresh = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(1350);
        drain();
        repeat (50) @(negedge clk);
        if (mismatches == 0 && result_queue.size() == 0)
            $display("** potential_field_contour_test_core: PASSED **");
        else
            $display("** potential_field_contour_test_core: FAILED **");
        $finish;
    end
endmodule

FILE: sim.f
src/pfct_pkg.sv
src/pfct_ctrl.sv
src/pfct_dp.sv
src/potential_field_contour_test_core.sv
test/testbench.sv
